// ===== hw/rtl/lzbd_pkg.sv =====
`default_nettype none

package lzbd_pkg;

  localparam int unsigned WINDOW_BYTES = 65536;
  localparam int unsigned HIST_AW      = $clog2(WINDOW_BYTES);
  localparam int unsigned OUT_CNT_W    = 24;
  localparam int unsigned CAP_W        = 24;

  localparam logic [CAP_W-1:0] CAP_RESET = 24'd65536;
  localparam logic [3:0]       NIB_EXT   = 4'hF;
  localparam logic [7:0]       BYTE_EXT  = 8'hFF;
  localparam logic [3:0]       MIN_MATCH = 4'd4;

  typedef enum logic [0:0] {
    OP_FEED = 1'b0,
    OP_PULL = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ERR_CAP    = 3'd0,
    ERR_ZERO   = 3'd1,
    ERR_FAR    = 3'd2,
    ERR_TRUNC  = 3'd3,
    ERR_MISUSE = 3'd4
  } err_code_t;

  typedef enum logic [6:0] {
    PH_TOKEN    = 7'b0000001,
    PH_LITEXT   = 7'b0000010,
    PH_LITERALS = 7'b0000100,
    PH_OFFLO    = 7'b0001000,
    PH_OFFHI    = 7'b0010000,
    PH_MATEXT   = 7'b0100000,
    PH_COPY     = 7'b1000000
  } phase_t;

  // history read request issued when the item is taken
  typedef struct packed {
    logic               en;
    logic [HIST_AW-1:0] addr;
  } hist_rd_t;

  // decoded item on its way to the output queue
  typedef struct packed {
    logic                 has_result;
    logic                 has_byte;
    logic                 copy;
    logic                 record;
    logic [HIST_AW-1:0]   waddr;
    logic [7:0]           data;
    logic                 final_res;
    logic                 error;
    err_code_t            error_code;
    logic [OUT_CNT_W-1:0] out_count;
  } stage_t;

  typedef struct packed {
    logic                 has_byte;
    logic [7:0]           out_byte;
    logic                 final_res;
    logic                 error;
    err_code_t            error_code;
    logic [OUT_CNT_W-1:0] out_count;
  } out_item_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lz4_block_decompressor.sv =====
`default_nettype none

// Decodes one LZ4 block per run of compressed bytes and takes one item per clock
// cycle with no bubbles while the result queue has room, for compressed bytes
// (tuser 0) and match pulls (tuser 1) alike. An item is parsed in the cycle it is
// taken; a match pull reads the 64 KiB history memory in that cycle and the byte
// comes back in the next cycle, with the entry written in that same cycle forwarded
// so an offset of 1 still runs at full rate. Results reach the output port through
// the read stage register and a three-entry queue; input ready depends only on the
// queue level and the beat in the read stage, so the block keeps taking items while
// a result waits on the output side. The history needs no clearing after reset.
module lz4_block_decompressor
  import lzbd_pkg::*;
#(
  parameter int unsigned COUNT_BITS = 24
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [CAP_W-1:0] cfg_wdata,      // out_capacity
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire logic [7:0]       s_axis_tdata,   // in_byte
  input  wire logic             s_axis_tuser,   // op
  input  wire logic             s_axis_tlast,   // in_last
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output logic [31:0]           m_axis_tdata,   // out_byte, out_count
  output logic [4:0]            m_axis_tuser,   // has_byte, error, error_code
  output logic                  m_axis_tlast    // final_res
);

  logic [CAP_W-1:0] out_capacity;
  logic             s_accept;
  hist_rd_t         hist_rd;
  stage_t           dec;
  logic             s1_valid;
  stage_t           s1;
  logic [7:0]       hist_q;
  logic [7:0]       s1_byte;
  logic             push;
  logic             pop;
  out_item_t        push_item;
  out_item_t        head;
  logic [1:0]       occupancy;
  logic [2:0]       inflight;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_capacity <= CAP_RESET;
    end else if (cfg_we) begin
      out_capacity <= cfg_wdata;
    end
  end

  // queue level plus the beat still in the read stage
  assign inflight      = {1'b0, occupancy} + {2'b0, s1_valid && s1.has_result};
  assign s_axis_tready = (inflight < 3'd3);
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  lzbd_parser #(
    .COUNT_BITS (COUNT_BITS)
  ) u_parser (
    .clk          (clk),
    .rst          (rst),
    .accept       (s_accept),
    .op           (op_t'(s_axis_tuser)),
    .in_byte      (s_axis_tdata),
    .in_last      (s_axis_tlast),
    .out_capacity (out_capacity),
    .hist_rd      (hist_rd),
    .res          (dec)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= s_accept;
    end
  end

  always_ff @(posedge clk) begin
    s1 <= dec;
  end

  assign s1_byte = s1.copy ? hist_q : s1.data;

  lzbd_history u_history (
    .clk     (clk),
    .rd      (hist_rd),
    .wr_en   (s1_valid && s1.record),
    .wr_addr (s1.waddr),
    .wr_data (s1_byte),
    .rd_data (hist_q)
  );

  assign push                 = s1_valid && s1.has_result;
  assign pop                  = m_axis_tvalid && m_axis_tready;
  assign push_item.has_byte   = s1.has_byte;
  assign push_item.out_byte   = s1_byte;
  assign push_item.final_res  = s1.final_res;
  assign push_item.error      = s1.error;
  assign push_item.error_code = s1.error_code;
  assign push_item.out_count  = s1.out_count;

  lzbd_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .not_empty (m_axis_tvalid),
    .head      (head),
    .occupancy (occupancy)
  );

  assign m_axis_tdata = {head.out_count, head.out_byte};
  assign m_axis_tuser = {head.error_code, head.error, head.has_byte};
  assign m_axis_tlast = head.final_res;

`ifndef SYNTH
  a_queue_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push && !pop |-> occupancy != 2'd3)
    else $error("result queue overflow");

  a_taken_item_reaches_stage: assert property (@(posedge clk) disable iff (rst)
    s_accept |=> s1_valid)
    else $error("accepted item lost before the read stage");

  a_final_not_error: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tlast && m_axis_tuser[1]))
    else $error("result both final and error");

  a_error_has_no_byte: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[1] |-> !m_axis_tuser[0])
    else $error("error result carries a byte");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/lzbd_history.sv =====
`default_nettype none

module lzbd_history
  import lzbd_pkg::*;
(
  input  wire logic               clk,
  input  wire hist_rd_t           rd,
  input  wire logic               wr_en,
  input  wire logic [HIST_AW-1:0] wr_addr,
  input  wire logic [7:0]         wr_data,
  output logic      [7:0]         rd_data
);

  logic [7:0] mem [WINDOW_BYTES];
  logic [7:0] mem_q;
  logic       fwd;
  logic [7:0] fwd_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd.en) begin
      mem_q <= mem[rd.addr];
    end
  end

  // a read of the entry written in the same cycle takes the new byte
  always_ff @(posedge clk) begin
    fwd      <= rd.en && wr_en && (wr_addr == rd.addr);
    fwd_data <= wr_data;
  end

  assign rd_data = fwd ? fwd_data : mem_q;

endmodule

`default_nettype wire

// ===== hw/rtl/lzbd_parser.sv =====
`default_nettype none

module lzbd_parser
  import lzbd_pkg::*;
#(
  parameter int unsigned COUNT_BITS = 24
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             accept,
  input  wire op_t              op,
  input  wire logic [7:0]       in_byte,
  input  wire logic             in_last,
  input  wire logic [CAP_W-1:0] out_capacity,
  output hist_rd_t              hist_rd,
  output stage_t                res
);

  localparam int unsigned LW = COUNT_BITS + 1;
  localparam int unsigned CW = (COUNT_BITS + 2 > CAP_W + 1) ? COUNT_BITS + 2 : CAP_W + 1;

  phase_t                phase, phase_next;
  logic [3:0]            match_nibble, match_nibble_next;
  logic [LW-1:0]         literal_left, literal_left_next;
  logic [LW-1:0]         match_left, match_left_next;
  logic [15:0]           match_distance, match_distance_next;
  logic [COUNT_BITS-1:0] produced, produced_next;
  logic                  input_ended, input_ended_next;

  logic [COUNT_BITS-1:0] prod_inc;
  logic [LW:0]           lit_sum;
  logic [LW-1:0]         lit_sat;
  logic [8:0]            mat_add;
  logic [LW:0]           mat_sum;
  logic [LW-1:0]         mat_sat;
  logic [LW-1:0]         tok_lit;
  logic [LW-1:0]         nib_len;
  logic [LW-1:0]         chk_len;
  logic [CW-1:0]         prod_w, inc_w;
  logic                  over;
  logic [15:0]           dist_full;
  logic                  restart;

  assign prod_inc = produced + COUNT_BITS'(1);
  assign prod_w   = CW'(produced);
  assign inc_w    = CW'(prod_inc);

  // saturating length accumulators
  assign lit_sum = {1'b0, literal_left} + (LW+1)'(in_byte);
  assign lit_sat = lit_sum[LW] ? {LW{1'b1}} : lit_sum[LW-1:0];
  assign mat_add = (in_byte == BYTE_EXT) ? {1'b0, in_byte} : ({1'b0, in_byte} + 9'(MIN_MATCH));
  assign mat_sum = {1'b0, match_left} + (LW+1)'(mat_add);
  assign mat_sat = mat_sum[LW] ? {LW{1'b1}} : mat_sum[LW-1:0];
  assign tok_lit = LW'(in_byte[7:4]);
  assign nib_len = LW'(match_nibble) + LW'(MIN_MATCH);

  always_comb begin
    unique case (phase)
      PH_LITEXT: chk_len = lit_sat;
      PH_OFFHI:  chk_len = nib_len;
      PH_MATEXT: chk_len = mat_sat;
      default:   chk_len = tok_lit;
    endcase
  end

  assign over      = (prod_w + CW'(chk_len)) > CW'(out_capacity);
  assign dist_full = {in_byte, match_distance[7:0]};

  always_comb begin
    phase_next          = phase;
    match_nibble_next   = match_nibble;
    literal_left_next   = literal_left;
    match_left_next     = match_left;
    match_distance_next = match_distance;
    produced_next       = produced;
    input_ended_next    = input_ended;
    restart             = 1'b0;
    hist_rd             = '0;
    res                 = '0;
    res.error_code      = ERR_CAP;
    res.waddr           = produced[HIST_AW-1:0];
    res.out_count       = prod_w[OUT_CNT_W-1:0];

    if (accept) begin
      if (op == OP_PULL) begin
        if (phase != PH_COPY) begin
          res.has_result = 1'b1;
          res.error      = 1'b1;
          res.error_code = ERR_MISUSE;
          restart        = 1'b1;
        end else begin
          hist_rd.en      = 1'b1;
          hist_rd.addr    = produced[HIST_AW-1:0] - match_distance;
          res.has_result  = 1'b1;
          res.has_byte    = 1'b1;
          res.copy        = 1'b1;
          res.record      = 1'b1;
          res.out_count   = inc_w[OUT_CNT_W-1:0];
          produced_next   = prod_inc;
          match_left_next = match_left - LW'(1);
          if (match_left == LW'(1)) begin
            if (input_ended) begin
              res.final_res = 1'b1;
              restart       = 1'b1;
            end else begin
              phase_next = PH_TOKEN;
            end
          end
        end
      end else begin
        unique case (phase)
          PH_TOKEN, PH_LITEXT: begin
            if (phase == PH_TOKEN) begin
              match_nibble_next = in_byte[3:0];
              literal_left_next = tok_lit;
            end else begin
              literal_left_next = lit_sat;
            end
            if ((phase == PH_TOKEN && in_byte[7:4] == NIB_EXT) ||
                (phase == PH_LITEXT && in_byte == BYTE_EXT)) begin
              phase_next = PH_LITEXT;
              if (in_last) begin
                res.has_result = 1'b1;
                res.error      = 1'b1;
                res.error_code = ERR_TRUNC;
                restart        = 1'b1;
              end
            end else if (over) begin
              res.has_result = 1'b1;
              res.error      = 1'b1;
              res.error_code = ERR_CAP;
              restart        = 1'b1;
            end else if (chk_len == '0) begin
              if (in_last) begin
                res.has_result = 1'b1;
                res.final_res  = 1'b1;
                restart        = 1'b1;
              end else begin
                phase_next = PH_OFFLO;
              end
            end else if (in_last) begin
              res.has_result = 1'b1;
              res.error      = 1'b1;
              res.error_code = ERR_TRUNC;
              restart        = 1'b1;
            end else begin
              phase_next = PH_LITERALS;
            end
          end
          PH_LITERALS: begin
            if (literal_left > LW'(1) && in_last) begin
              res.has_result = 1'b1;
              res.error      = 1'b1;
              res.error_code = ERR_TRUNC;
              restart        = 1'b1;
            end else begin
              res.has_result    = 1'b1;
              res.has_byte      = 1'b1;
              res.record        = 1'b1;
              res.data          = in_byte;
              res.out_count     = inc_w[OUT_CNT_W-1:0];
              produced_next     = prod_inc;
              literal_left_next = literal_left - LW'(1);
              if (literal_left == LW'(1)) begin
                if (in_last) begin
                  res.final_res = 1'b1;
                  restart       = 1'b1;
                end else begin
                  phase_next = PH_OFFLO;
                end
              end
            end
          end
          PH_OFFLO: begin
            if (in_last) begin
              res.has_result = 1'b1;
              res.error      = 1'b1;
              res.error_code = ERR_TRUNC;
              restart        = 1'b1;
            end else begin
              match_distance_next = {8'd0, in_byte};
              phase_next          = PH_OFFHI;
            end
          end
          PH_OFFHI: begin
            match_distance_next = dist_full;
            if (dist_full == 16'd0) begin
              res.has_result = 1'b1;
              res.error      = 1'b1;
              res.error_code = ERR_ZERO;
              restart        = 1'b1;
            end else if (COUNT_BITS'(dist_full) > produced) begin
              res.has_result = 1'b1;
              res.error      = 1'b1;
              res.error_code = ERR_FAR;
              restart        = 1'b1;
            end else if (match_nibble == NIB_EXT) begin
              match_left_next = LW'(match_nibble);
              phase_next      = PH_MATEXT;
              if (in_last) begin
                res.has_result = 1'b1;
                res.error      = 1'b1;
                res.error_code = ERR_TRUNC;
                restart        = 1'b1;
              end
            end else if (over) begin
              res.has_result = 1'b1;
              res.error      = 1'b1;
              res.error_code = ERR_CAP;
              restart        = 1'b1;
            end else begin
              match_left_next  = nib_len;
              input_ended_next = in_last;
              phase_next       = PH_COPY;
            end
          end
          PH_MATEXT: begin
            match_left_next = mat_sat;
            if (in_byte == BYTE_EXT) begin
              if (in_last) begin
                res.has_result = 1'b1;
                res.error      = 1'b1;
                res.error_code = ERR_TRUNC;
                restart        = 1'b1;
              end
            end else if (over) begin
              res.has_result = 1'b1;
              res.error      = 1'b1;
              res.error_code = ERR_CAP;
              restart        = 1'b1;
            end else begin
              input_ended_next = in_last;
              phase_next       = PH_COPY;
            end
          end
          default: begin
            // feeding a byte while match bytes are still owed
            res.has_result = 1'b1;
            res.error      = 1'b1;
            res.error_code = ERR_MISUSE;
            restart        = 1'b1;
          end
        endcase
      end
    end

    if (restart) begin
      phase_next          = PH_TOKEN;
      match_nibble_next   = '0;
      literal_left_next   = '0;
      match_left_next     = '0;
      match_distance_next = '0;
      produced_next       = '0;
      input_ended_next    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_TOKEN;
      match_nibble   <= '0;
      literal_left   <= '0;
      match_left     <= '0;
      match_distance <= '0;
      produced       <= '0;
      input_ended    <= 1'b0;
    end else begin
      phase          <= phase_next;
      match_nibble   <= match_nibble_next;
      literal_left   <= literal_left_next;
      match_left     <= match_left_next;
      match_distance <= match_distance_next;
      produced       <= produced_next;
      input_ended    <= input_ended_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lzbd_out_fifo.sv =====
`default_nettype none

module lzbd_out_fifo
  import lzbd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire out_item_t push_item,
  input  wire logic      pop,
  output logic           not_empty,
  output out_item_t      head,
  output logic [1:0]     occupancy
);

  localparam logic [1:0] LAST_SLOT = 2'd2;

  out_item_t  slots [3];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? 2'd0 : wr_ptr + 2'd1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? 2'd0 : rd_ptr + 2'd1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  assign not_empty = (count != 2'd0);
  assign head      = slots[rd_ptr];
  assign occupancy = count;

endmodule

`default_nettype wire
